FILE: src/hdcr_pkg.sv
package hdcr_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_TRACK_COUNT = 3'd0;
  localparam logic [2:0] CFG_HEAD_COUNT  = 3'd1;
  localparam logic [2:0] CFG_SPT         = 3'd2;
  localparam logic [2:0] CFG_SECTOR_B    = 3'd3;
  localparam logic [2:0] CFG_READY_MASK  = 3'd4;
  localparam logic [2:0] CFG_WR_FAULT    = 3'd5;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 12;

  // command codes
  localparam logic [2:0] OP_NULL  = 3'd0;
  localparam logic [2:0] OP_RDATA = 3'd1;
  localparam logic [2:0] OP_WDATA = 3'd2;
  localparam logic [2:0] OP_WHDR  = 3'd3;
  localparam logic [2:0] OP_RHDR  = 3'd4;

  // bus access kinds and ports
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;
  localparam logic PORT_CTRL = 1'b0;
  localparam logic PORT_DATA = 1'b1;

  // multiplier operand selects
  localparam logic [1:0] MUL_SEL_POS = 2'd0;  // track * heads + head
  localparam logic [1:0] MUL_SEL_TRK = 2'd1;  // sectors * (bytes + 3)
  localparam logic [1:0] MUL_SEL_HDR = 2'd2;  // header sector * (bytes + 3)
  localparam logic [1:0] MUL_SEL_OFF = 2'd3;  // position * track length

  localparam logic [9:0] TRACK_RESET = 10'd5;
  localparam logic [7:0] STEP_RDATA  = 8'hFF;

  typedef struct packed {
    logic       capture;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       commit;
  } hdcr_cmd_t;

  typedef struct packed {
    logic need_mul;
    logic out_free;
  } hdcr_sts_t;

endpackage

FILE: src/hdcr_ctrl.sv
module hdcr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hdcr_pkg::hdcr_sts_t sts_i,
  output hdcr_pkg::hdcr_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MPOS  = 3'd1;
  localparam logic [2:0] S_MTRK  = 3'd2;
  localparam logic [2:0] S_MHDR  = 3'd3;
  localparam logic [2:0] S_MOFF  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = hdcr_pkg::MUL_SEL_POS;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = sts_i.need_mul ? S_MPOS : S_DONE;
        end
      end
      S_MPOS: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = hdcr_pkg::MUL_SEL_POS;
        state_d = S_MTRK;
      end
      S_MTRK: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = hdcr_pkg::MUL_SEL_TRK;
        state_d = S_MHDR;
      end
      S_MHDR: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = hdcr_pkg::MUL_SEL_HDR;
        state_d = S_MOFF;
      end
      S_MOFF: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = hdcr_pkg::MUL_SEL_OFF;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/hdcr_dp.sv
module hdcr_dp #(
  parameter int DRIVES = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hdcr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hdcr_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          req_type_i,
  input  logic                          port_i,
  input  logic [7:0]                    wdata_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    rdata_o,
  output logic                          irq_o,
  output logic                          cmd_valid_o,
  output logic [2:0]                    cmd_code_o,
  output logic [1:0]                    drive_index_o,
  output logic [31:0]                   byte_offset_o,
  output logic [7:0]                    target_cyl_o,
  output logic [7:0]                    target_head_o,
  output logic [7:0]                    target_sector_o,
  input  hdcr_pkg::hdcr_cmd_t           cmd_i,
  output hdcr_pkg::hdcr_sts_t           sts_o
);

  localparam int DrvW   = (DRIVES > 1) ? $clog2(DRIVES) : 1;
  localparam int NumTrk = 1 << DrvW;

  // configuration
  logic [9:0]  tcount_q;
  logic [4:0]  hcount_q;
  logic [7:0]  spt_q;
  logic [11:0] sbytes_q;
  logic [3:0]  ready_q;
  logic        wfault_q;

  // controller state
  logic [1:0]  sel_q;
  logic [3:0]  hsel_q;
  logic [7:0]  head_q, cyl_q, sec_q, hsec_q;
  logic [2:0]  op_q;
  logic        att_q, tmo_q, seek_q;
  logic [9:0]  trk_q [NumTrk];

  // captured item
  logic        req_q, port_q;
  logic [7:0]  wd_q;

  // multiplier and partial results
  logic [15:0] mul_a;
  logic [20:0] mul_b;
  logic [36:0] mul_p;
  logic [15:0] pos_q;
  logic [20:0] tlen_q, hoff_q;
  logic [31:0] off_q;

  logic [DrvW-1:0] drv;
  logic [9:0]  cur_trk;
  logic [12:0] unit_len;
  logic [2:0]  new_op;
  logic        is_stat, is_step, is_ctrl, is_par, run, known_op;
  logic [7:0]  hsec_inc;
  logic [2:0]  nd;

  // result
  logic [7:0]  res_rdata;
  logic        res_irq, res_valid;
  logic [2:0]  res_code;
  logic [31:0] res_off;
  logic [7:0]  res_cyl, res_head, res_sec;

  assign drv      = sel_q[DrvW-1:0];
  assign cur_trk  = trk_q[drv];
  assign unit_len = 13'(sbytes_q) + 13'd3;
  assign new_op   = wd_q[5:3];
  assign run      = wd_q[6];
  assign is_stat  = (req_q == hdcr_pkg::REQ_READ)  && (port_q == hdcr_pkg::PORT_CTRL);
  assign is_step  = (req_q == hdcr_pkg::REQ_READ)  && (port_q == hdcr_pkg::PORT_DATA);
  assign is_ctrl  = (req_q == hdcr_pkg::REQ_WRITE) && (port_q == hdcr_pkg::PORT_CTRL);
  assign is_par   = (req_q == hdcr_pkg::REQ_WRITE) && (port_q == hdcr_pkg::PORT_DATA);
  assign known_op = (new_op inside {[hdcr_pkg::OP_NULL:hdcr_pkg::OP_RHDR]});
  assign hsec_inc = hsec_q + 8'd1;

  assign sts_o.need_mul = (req_type_i == hdcr_pkg::REQ_WRITE) &&
                          (port_i == hdcr_pkg::PORT_CTRL) && wdata_i[6] &&
                          (wdata_i[5:3] inside {[hdcr_pkg::OP_RDATA:hdcr_pkg::OP_RHDR]});
  assign sts_o.out_free = !out_valid_o || !out_stall_i;

  // shared multiplier
  always_comb begin
    case (cmd_i.mul_sel)
      hdcr_pkg::MUL_SEL_POS: begin
        if (new_op == hdcr_pkg::OP_RDATA || new_op == hdcr_pkg::OP_WDATA) begin
          mul_a = 16'(cyl_q);
        end else begin
          mul_a = 16'(cur_trk);
        end
        mul_b = 21'(hcount_q);
      end
      hdcr_pkg::MUL_SEL_TRK: begin
        mul_a = 16'(spt_q);
        mul_b = 21'(unit_len);
      end
      hdcr_pkg::MUL_SEL_HDR: begin
        mul_a = 16'(hsec_q);
        mul_b = 21'(unit_len);
      end
      default: begin
        mul_a = pos_q;
        mul_b = tlen_q;
      end
    endcase
  end

  assign mul_p = 37'(mul_a) * 37'(mul_b);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_type_i;
      port_q <= port_i;
      wd_q   <= wdata_i;
    end
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        hdcr_pkg::MUL_SEL_POS: pos_q  <= mul_p[15:0] + 16'(hsel_q);
        hdcr_pkg::MUL_SEL_TRK: tlen_q <= mul_p[20:0];
        hdcr_pkg::MUL_SEL_HDR: hoff_q <= mul_p[20:0];
        default:               off_q  <= mul_p[31:0];
      endcase
    end
  end

  // drive select decode: one-hot upper nibble, else no drive
  always_comb begin
    case (wd_q[7:4])
      4'h1:    nd = 3'd0;
      4'h2:    nd = 3'd1;
      4'h4:    nd = 3'd2;
      4'h8:    nd = 3'd3;
      default: nd = 3'd4;
    endcase
  end

  // result of the captured item
  always_comb begin
    res_rdata = '0;
    res_irq   = 1'b0;
    res_valid = 1'b0;
    res_code  = hdcr_pkg::OP_NULL;
    res_off   = '0;
    res_cyl   = '0;
    res_head  = '0;
    res_sec   = '0;
    if (is_stat) begin
      res_rdata = {att_q, tmo_q, 2'b00, !ready_q[sel_q], !seek_q, wfault_q,
                   (cur_trk != 10'd0) || !seek_q};
    end else if (is_step) begin
      res_rdata = hdcr_pkg::STEP_RDATA;
    end else if (is_ctrl && run) begin
      res_irq   = 1'b1;
      res_valid = known_op;
      if (known_op) res_code = new_op;
      if (new_op == hdcr_pkg::OP_RDATA || new_op == hdcr_pkg::OP_WDATA) begin
        res_off  = off_q;
        res_cyl  = cyl_q;
        res_head = head_q;
        res_sec  = sec_q;
      end else if (new_op == hdcr_pkg::OP_WHDR) begin
        res_off  = off_q + 32'(hoff_q);
      end else if (new_op == hdcr_pkg::OP_RHDR) begin
        res_off  = off_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rdata_o         <= res_rdata;
      irq_o           <= res_irq;
      cmd_valid_o     <= res_valid;
      cmd_code_o      <= res_code;
      drive_index_o   <= res_valid ? sel_q : 2'd0;
      byte_offset_o   <= res_off;
      target_cyl_o    <= res_cyl;
      target_head_o   <= res_head;
      target_sector_o <= res_sec;
    end
  end

  // configuration and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcount_q <= 10'd243;
      hcount_q <= 5'd8;
      spt_q    <= 8'd11;
      sbytes_q <= 12'd1024;
      ready_q  <= '0;
      wfault_q <= 1'b0;
      sel_q    <= '0;
      hsel_q   <= '0;
      head_q   <= '0;
      cyl_q    <= '0;
      sec_q    <= '0;
      hsec_q   <= '0;
      op_q     <= hdcr_pkg::OP_NULL;
      att_q    <= 1'b0;
      tmo_q    <= 1'b0;
      seek_q   <= 1'b0;
      for (int i = 0; i < NumTrk; i++) begin
        trk_q[i] <= hdcr_pkg::TRACK_RESET;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          hdcr_pkg::CFG_TRACK_COUNT: tcount_q <= cfg_wdata_i[9:0];
          hdcr_pkg::CFG_HEAD_COUNT:  hcount_q <= cfg_wdata_i[4:0];
          hdcr_pkg::CFG_SPT:         spt_q    <= cfg_wdata_i[7:0];
          hdcr_pkg::CFG_SECTOR_B:    sbytes_q <= cfg_wdata_i;
          hdcr_pkg::CFG_READY_MASK:  ready_q  <= cfg_wdata_i[3:0];
          hdcr_pkg::CFG_WR_FAULT:    wfault_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (cmd_i.commit) begin
        if (is_stat) begin
          seek_q <= 1'b1;
        end else if (is_step) begin
          if (op_q[2]) begin
            if (cur_trk < tcount_q) trk_q[drv] <= cur_trk + 10'd1;
          end else if (cur_trk != 10'd0) begin
            trk_q[drv] <= cur_trk - 10'd1;
          end
          seek_q <= 1'b0;
        end else if (is_ctrl) begin
          att_q  <= wd_q[7] && !run;
          op_q   <= new_op;
          seek_q <= 1'b1;
          if (run && (new_op == hdcr_pkg::OP_WHDR) && (hsec_inc >= spt_q)) begin
            tmo_q <= 1'b1;
          end else if (wd_q[2] || run) begin
            tmo_q <= 1'b0;
          end
          if (run) begin
            if (new_op == hdcr_pkg::OP_RDATA || new_op == hdcr_pkg::OP_WDATA) begin
              trk_q[drv] <= 10'(cyl_q);
            end else if (new_op == hdcr_pkg::OP_WHDR) begin
              if (hsec_inc >= spt_q) begin
                hsec_q <= '0;
              end else begin
                hsec_q <= hsec_inc;
              end
            end
          end
        end else if (is_par) begin
          case (op_q)
            hdcr_pkg::OP_NULL: begin
              if (32'(nd) < DRIVES) sel_q <= nd[1:0];
              hsel_q <= wd_q[3:0];
            end
            hdcr_pkg::OP_RDATA: cyl_q  <= wd_q;
            hdcr_pkg::OP_WDATA: head_q <= wd_q;
            hdcr_pkg::OP_WHDR:  sec_q  <= wd_q;
            default: ;
          endcase
        end
      end
    end
  end

endmodule

FILE: src/hard_disk_controller_registers.sv
// Channel  Handshake                   Payload
// in       in_valid_i / in_stall_o     req_type_i, port_i, wdata_i
// out      out_valid_o / out_stall_i   rdata_o, irq_o, cmd_valid_o, cmd_code_o,
//                                      drive_index_o, byte_offset_o, target_*_o
// cfg      cfg_we_i                    cfg_idx_i, cfg_wdata_i
//
// A plain access goes from capture straight to the final state that loads the
// output register; for a run command with operation 1 to 4 the offset first
// passes four times through one shared 16x21 multiplier (position, track length,
// header offset, product). The input is stalled until the result is loaded, and
// a stalled output keeps the controller waiting in its final state.
// Reset is asynchronous, active low, and restores geometry and tracks at once.
module hard_disk_controller_registers #(
  parameter int DRIVES = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [hdcr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hdcr_pkg::CfgDataW-1:0] cfg_wdata_i,
  // bus access items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic                          port_i,
  input  logic [7:0]                    wdata_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    rdata_o,
  output logic                          irq_o,
  output logic                          cmd_valid_o,
  output logic [2:0]                    cmd_code_o,
  output logic [1:0]                    drive_index_o,
  output logic [31:0]                   byte_offset_o,
  output logic [7:0]                    target_cyl_o,
  output logic [7:0]                    target_head_o,
  output logic [7:0]                    target_sector_o
);

  // controller drives the sequencing, datapath holds the configuration, state and output registers
  hdcr_pkg::hdcr_cmd_t cmd;
  hdcr_pkg::hdcr_sts_t sts;

  hdcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hdcr_dp #(
    .DRIVES (DRIVES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_type_i      (req_type_i),
    .port_i          (port_i),
    .wdata_i         (wdata_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .rdata_o         (rdata_o),
    .irq_o           (irq_o),
    .cmd_valid_o     (cmd_valid_o),
    .cmd_code_o      (cmd_code_o),
    .drive_index_o   (drive_index_o),
    .byte_offset_o   (byte_offset_o),
    .target_cyl_o    (target_cyl_o),
    .target_head_o   (target_head_o),
    .target_sector_o (target_sector_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

FILE: tb/tb_hard_disk_controller_registers.sv
`timescale 1ns / 1ps

module tb_hard_disk_controller_registers;

  localparam int DRIVES         = 4;
  localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
  localparam int LONG_HOLD      = 80;    // receiver hold-off, long enough to back up the input
  localparam int SETTLE_CYCLES  = 10;    // extra wait once every result is back
  localparam int MAX_REPORTS    = 60;

  // control byte fields
  localparam logic [7:0] CTRL_ATTN   = 8'h80;
  localparam logic [7:0] CTRL_RUN    = 8'h40;
  localparam logic [7:0] CTRL_CLR_TO = 8'h04;

  // operations the controller does not know
  localparam logic [2:0] OP_UNKNOWN_5 = 3'd5;
  localparam logic [2:0] OP_UNKNOWN_7 = 3'd7;

  typedef struct packed {
    logic       req_type;
    logic       port;
    logic [7:0] wdata;
  } bus_access_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic        irq;
    logic        cmd_valid;
    logic [2:0]  cmd_code;
    logic [1:0]  drive_index;
    logic [31:0] byte_offset;
    logic [7:0]  tcyl;
    logic [7:0]  thead;
    logic [7:0]  tsec;
  } disk_resp_t;

  // ports of the block; everything starts known
  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [hdcr_pkg::CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [hdcr_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  logic                          req_type_i  = 1'b0;
  logic                          port_i      = 1'b0;
  logic [7:0]                    wdata_i     = 8'h00;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [7:0]                    rdata_o;
  logic                          irq_o;
  logic                          cmd_valid_o;
  logic [2:0]                    cmd_code_o;
  logic [1:0]                    drive_index_o;
  logic [31:0]                   byte_offset_o;
  logic [7:0]                    target_cyl_o;
  logic [7:0]                    target_head_o;
  logic [7:0]                    target_sector_o;

  // stimulus and scoreboard
  bus_access_t access_q[$];          // items waiting for the driver
  disk_resp_t  expected_resp_q[$];   // predicted results, oldest first
  bus_access_t cur_access;
  logic        offering    = 1'b0;   // driver has an item on the bus
  logic        sender_hold = 1'b0;   // stop offering new items
  logic        idle_on     = 1'b1;   // random gaps and stalls enabled
  int          gap_left    = 0;
  int          rx_hold_req = 0;      // bumped to ask for a long receiver hold
  int          n_fail      = 0;

  // geometry as the controller should currently see it
  logic [9:0]  cfg_tracks;
  logic [4:0]  cfg_heads;
  logic [7:0]  cfg_spt;
  logic [11:0] cfg_sec_bytes;
  logic [3:0]  cfg_ready;
  logic        cfg_wr_fault;

  // controller registers as predicted
  logic [1:0]  m_drive;
  logic [3:0]  m_head_sel;
  logic [7:0]  m_head;
  logic [7:0]  m_cyl;
  logic [7:0]  m_sector;
  logic [7:0]  m_hdr_sec;
  logic [2:0]  m_op;
  logic        m_attn;
  logic        m_timeout;
  logic        m_seek_done;
  logic [9:0]  m_track [DRIVES];

  hard_disk_controller_registers #(
    .DRIVES(DRIVES)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .port_i         (port_i),
    .wdata_i        (wdata_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .rdata_o        (rdata_o),
    .irq_o          (irq_o),
    .cmd_valid_o    (cmd_valid_o),
    .cmd_code_o     (cmd_code_o),
    .drive_index_o  (drive_index_o),
    .byte_offset_o  (byte_offset_o),
    .target_cyl_o   (target_cyl_o),
    .target_head_o  (target_head_o),
    .target_sector_o(target_sector_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Works out the result of one bus access and moves the predicted
  // registers on, in the order the controller applies them.
  function automatic disk_resp_t predict_access(input bus_access_t a);
    disk_resp_t  r;
    logic [1:0]  drv;
    logic [63:0] unit_len;
    logic [63:0] trk_len;
    logic [63:0] pos;
    logic [63:0] offs;
    r    = '0;
    offs = '0;
    drv  = m_drive;
    if (a.req_type == hdcr_pkg::REQ_READ && a.port == hdcr_pkg::PORT_CTRL) begin
      // status byte; reading it completes any pending seek
      r.rdata[7]  = m_attn;
      r.rdata[6]  = m_timeout;
      r.rdata[3]  = !cfg_ready[drv];
      r.rdata[2]  = !m_seek_done;
      r.rdata[1]  = cfg_wr_fault;
      r.rdata[0]  = (m_track[drv] != '0) || !m_seek_done;
      m_seek_done = 1'b1;
    end else if (a.req_type == hdcr_pkg::REQ_READ) begin
      // step pulse: op bit 2 chooses inward, bounded by the track count
      if (m_op[2]) begin
        if (m_track[drv] < cfg_tracks) m_track[drv] = m_track[drv] + 10'd1;
      end else if (m_track[drv] != '0) begin
        m_track[drv] = m_track[drv] - 10'd1;
      end
      m_seek_done = 1'b0;
      r.rdata     = hdcr_pkg::STEP_RDATA;
    end else if (a.port == hdcr_pkg::PORT_CTRL) begin
      m_attn = a.wdata[7];
      m_op   = a.wdata[5:3];
      if (a.wdata[2]) m_timeout = 1'b0;
      m_seek_done = 1'b1;
      if (a.wdata[6]) begin
        unit_len    = 64'(cfg_sec_bytes) + 64'd3;
        trk_len     = unit_len * 64'(cfg_spt);
        m_timeout   = 1'b0;
        r.cmd_valid = 1'b1;
        case (m_op)
          hdcr_pkg::OP_NULL: begin
          end
          hdcr_pkg::OP_RDATA, hdcr_pkg::OP_WDATA: begin
            m_track[drv] = {2'b00, m_cyl};
            pos          = 64'(m_cyl) * 64'(cfg_heads) + 64'(m_head_sel);
            offs         = pos * trk_len;
            r.tcyl       = m_cyl;
            r.thead      = m_head;
            r.tsec       = m_sector;
          end
          hdcr_pkg::OP_WHDR: begin
            pos       = 64'(m_track[drv]) * 64'(cfg_heads) + 64'(m_head_sel);
            offs      = pos * trk_len + unit_len * 64'(m_hdr_sec);
            m_hdr_sec = m_hdr_sec + 8'd1;
            if (m_hdr_sec >= cfg_spt) begin
              m_hdr_sec = '0;
              m_timeout = 1'b1;
            end
          end
          hdcr_pkg::OP_RHDR: begin
            pos  = 64'(m_track[drv]) * 64'(cfg_heads) + 64'(m_head_sel);
            offs = pos * trk_len;
          end
          default: r.cmd_valid = 1'b0;
        endcase
        r.byte_offset = offs[31:0];
        if (r.cmd_valid) begin
          r.cmd_code    = m_op;
          r.drive_index = drv;
        end
        r.irq  = 1'b1;
        m_attn = 1'b0;
      end
    end else begin
      case (m_op)
        hdcr_pkg::OP_NULL: begin
          // drive select wants exactly one bit in the upper nibble
          case (a.wdata[7:4])
            4'b0001: m_drive = 2'd0;
            4'b0010: m_drive = 2'd1;
            4'b0100: m_drive = 2'd2;
            4'b1000: m_drive = 2'd3;
            default: ;
          endcase
          m_head_sel = a.wdata[3:0];
        end
        hdcr_pkg::OP_RDATA: m_cyl    = a.wdata;
        hdcr_pkg::OP_WDATA: m_head   = a.wdata;
        hdcr_pkg::OP_WHDR:  m_sector = a.wdata;
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      n_fail++;
      if (n_fail <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  task automatic push_access(input logic rw, input logic prt, input logic [7:0] wd);
    bus_access_t a;
    a.req_type = rw;
    a.port     = prt;
    a.wdata    = wd;
    access_q.push_back(a);
  endtask

  function automatic logic [7:0] op_bits(input logic [2:0] op);
    return {2'b00, op, 3'b000};
  endfunction

  // control write with the given op and run bit, other bits random
  function automatic logic [7:0] ctrl_word(input logic [2:0] op, input logic run);
    logic [7:0] b;
    b      = 8'($urandom);
    b[5:3] = op;
    b[6]   = run;
    return b;
  endfunction

  // Register writes; the controller is idle whenever this is called.
  task automatic write_cfg(input logic [hdcr_pkg::CfgIdxW-1:0] idx,
                           input logic [hdcr_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      hdcr_pkg::CFG_TRACK_COUNT: cfg_tracks    = val[9:0];
      hdcr_pkg::CFG_HEAD_COUNT:  cfg_heads     = val[4:0];
      hdcr_pkg::CFG_SPT:         cfg_spt       = val[7:0];
      hdcr_pkg::CFG_SECTOR_B:    cfg_sec_bytes = val[11:0];
      hdcr_pkg::CFG_READY_MASK:  cfg_ready     = val[3:0];
      hdcr_pkg::CFG_WR_FAULT:    cfg_wr_fault  = val[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_geometry(input logic [9:0] trk, input logic [4:0] hds,
                                input logic [7:0] spt, input logic [11:0] sb,
                                input logic [3:0] rdy, input logic wf);
    write_cfg(hdcr_pkg::CFG_TRACK_COUNT, hdcr_pkg::CfgDataW'(trk));
    write_cfg(hdcr_pkg::CFG_HEAD_COUNT,  hdcr_pkg::CfgDataW'(hds));
    write_cfg(hdcr_pkg::CFG_SPT,         hdcr_pkg::CfgDataW'(spt));
    write_cfg(hdcr_pkg::CFG_SECTOR_B,    sb);
    write_cfg(hdcr_pkg::CFG_READY_MASK,  hdcr_pkg::CfgDataW'(rdy));
    write_cfg(hdcr_pkg::CFG_WR_FAULT,    hdcr_pkg::CfgDataW'(wf));
    @(negedge clk_i);
  endtask

  // Mostly well-formed host sequences: set up drive, cylinder, head and
  // sector, then run a command; or set a direction and pulse the stepper.
  // The remainder is raw noise.
  task automatic add_random_traffic(input int n);
    int         target;
    int         kind;
    int         k;
    logic [3:0] hi;
    target = access_q.size() + n;
    while (access_q.size() < target) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        if ($urandom_range(0, 2) != 0) begin
          push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_CTRL,
                      ctrl_word(hdcr_pkg::OP_NULL, 1'b0));
          hi = 4'b0001 << $urandom_range(0, 3);
          if ($urandom_range(0, 4) == 0) hi = 4'($urandom);
          push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_DATA, {hi, 4'($urandom)});
        end
        if ($urandom_range(0, 1) != 0) begin
          push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_CTRL,
                      ctrl_word(hdcr_pkg::OP_RDATA, 1'b0));
          push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_DATA, 8'($urandom));
        end
        if ($urandom_range(0, 1) != 0) begin
          push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_CTRL,
                      ctrl_word(hdcr_pkg::OP_WDATA, 1'b0));
          push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_DATA, 8'($urandom));
          push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_CTRL,
                      ctrl_word(hdcr_pkg::OP_WHDR, 1'b0));
          push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_DATA, 8'($urandom));
        end
        if ($urandom_range(0, 9) < 8)
          push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_CTRL,
                      ctrl_word(3'($urandom_range(0, 4)), 1'b1));
        else
          push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_CTRL,
                      ctrl_word(3'($urandom_range(5, 7)), 1'b1));
        if ($urandom_range(0, 1) != 0)
          push_access(hdcr_pkg::REQ_READ, hdcr_pkg::PORT_CTRL, 8'($urandom));
      end else if (kind < 8) begin
        push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_CTRL, ctrl_word(3'($urandom), 1'b0));
        for (k = $urandom_range(1, 8); k > 0; k--)
          push_access(hdcr_pkg::REQ_READ, hdcr_pkg::PORT_DATA, 8'($urandom));
        push_access(hdcr_pkg::REQ_READ, hdcr_pkg::PORT_CTRL, 8'($urandom));
      end else begin
        for (k = $urandom_range(1, 4); k > 0; k--)
          push_access(1'($urandom), 1'($urandom), 8'($urandom));
      end
    end
  endtask

  // Waits until every item went in and every result came back, then lets
  // the pipeline settle.
  task automatic wait_drained();
    while (access_q.size() != 0 || offering || expected_resp_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Driver: one item at a time; valid stays up until the item is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_resp_q.push_back(predict_access(cur_access));
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (access_q.size() != 0 && !sender_hold) begin
          cur_access = access_q.pop_front();
          offering   = 1'b1;
          req_type_i <= cur_access.req_type;
          port_i     <= cur_access.port;
          wdata_i    <= cur_access.wdata;
          if (idle_on && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 9);
        end
      end
      in_valid_i <= offering;
    end
  end

  // Monitor: compares taken results and drives the output stall.
  always @(posedge clk_i) begin : result_monitor
    disk_resp_t want;
    logic       stall_next;
    int         hold_served;
    int         hold_cycles;
    int         stall_left;
    if (!rst_ni) begin
      hold_served = 0;
      hold_cycles = 0;
      stall_left  = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_resp_q.size() == 0) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual rdata %0h irq %0b cmd %0b",
                     $time, rdata_o, irq_o, cmd_valid_o);
        end else begin
          want = expected_resp_q.pop_front();
          check_field("rdata",         32'(want.rdata),       32'(rdata_o));
          check_field("irq",           32'(want.irq),         32'(irq_o));
          check_field("cmd_valid",     32'(want.cmd_valid),   32'(cmd_valid_o));
          check_field("cmd_code",      32'(want.cmd_code),    32'(cmd_code_o));
          check_field("drive_index",   32'(want.drive_index), 32'(drive_index_o));
          check_field("byte_offset",   want.byte_offset,      byte_offset_o);
          check_field("target_cyl",    32'(want.tcyl),        32'(target_cyl_o));
          check_field("target_head",   32'(want.thead),       32'(target_head_o));
          check_field("target_sector", 32'(want.tsec),        32'(target_sector_o));
        end
      end
      if (hold_served != rx_hold_req) begin
        hold_served = rx_hold_req;
        hold_cycles = LONG_HOLD;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        stall_next = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall_next = 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      out_stall_i <= stall_next;
    end
  end

  // Watchdog: a long spell with nothing taken on either side means a hang.
  always @(posedge clk_i) begin : hang_watch
    int quiet;
    if (!rst_ni) begin
      quiet = 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("hard_disk_controller_registers verification failed");
        $finish;
      end
    end
  end

  initial begin
    int ph;
    int k;
    // power-on state of the controller
    cfg_tracks    = 10'd243;
    cfg_heads     = 5'd8;
    cfg_spt       = 8'd11;
    cfg_sec_bytes = 12'd1024;
    cfg_ready     = '0;
    cfg_wr_fault  = 1'b0;
    m_drive       = '0;
    m_head_sel    = '0;
    m_head        = '0;
    m_cyl         = '0;
    m_sector      = '0;
    m_hdr_sec     = '0;
    m_op          = hdcr_pkg::OP_NULL;
    m_attn        = 1'b0;
    m_timeout     = 1'b0;
    m_seek_done   = 1'b0;
    for (k = 0; k < DRIVES; k++) m_track[k] = hdcr_pkg::TRACK_RESET;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed pass on the reset geometry: status before any seek, stepping
    // both ways, drive select good and bad, every command, unknown ops and
    // an ignored parameter write.
    push_access(hdcr_pkg::REQ_READ,  hdcr_pkg::PORT_CTRL, 8'h00);
    push_access(hdcr_pkg::REQ_READ,  hdcr_pkg::PORT_DATA, 8'h00);
    push_access(hdcr_pkg::REQ_READ,  hdcr_pkg::PORT_CTRL, 8'hFF);
    push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_CTRL,
                CTRL_ATTN | op_bits(hdcr_pkg::OP_RHDR));
    push_access(hdcr_pkg::REQ_READ,  hdcr_pkg::PORT_DATA, 8'h00);
    push_access(hdcr_pkg::REQ_READ,  hdcr_pkg::PORT_CTRL, 8'h00);
    push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_CTRL, op_bits(hdcr_pkg::OP_NULL));
    push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_DATA, 8'h8F);
    push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_DATA, 8'h35);
    push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_CTRL, op_bits(hdcr_pkg::OP_RDATA));
    push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_DATA, 8'hFF);
    push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_CTRL, op_bits(hdcr_pkg::OP_WDATA));
    push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_DATA, 8'hAB);
    push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_CTRL, op_bits(hdcr_pkg::OP_WHDR));
    push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_DATA, 8'h00);
    push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_CTRL,
                CTRL_RUN | op_bits(hdcr_pkg::OP_RDATA));
    push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_CTRL,
                CTRL_ATTN | CTRL_RUN | op_bits(hdcr_pkg::OP_WDATA));
    push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_CTRL,
                CTRL_RUN | op_bits(hdcr_pkg::OP_WHDR));
    push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_CTRL,
                CTRL_RUN | op_bits(hdcr_pkg::OP_RHDR));
    push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_CTRL,
                CTRL_RUN | op_bits(hdcr_pkg::OP_NULL) | 8'h03);
    push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_CTRL,
                CTRL_ATTN | CTRL_RUN | op_bits(OP_UNKNOWN_7));
    push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_CTRL, op_bits(OP_UNKNOWN_5));
    push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_DATA, 8'h5A);
    push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_CTRL,
                CTRL_CLR_TO | op_bits(hdcr_pkg::OP_NULL));
    push_access(hdcr_pkg::REQ_READ,  hdcr_pkg::PORT_CTRL, 8'h00);
    wait_drained();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: apply_geometry(10'd1023, 5'd16, 8'd255, 12'd2048, 4'hF, 1'b1);
        1: apply_geometry(10'd1, 5'd1, 8'd1, 12'd1, 4'h0, 1'b0);
        // zero geometry: offsets collapse, step-in cannot move
        2: apply_geometry(10'd0, 5'd0, 8'd0, 12'd0, 4'($urandom), 1'($urandom));
        3, 4: apply_geometry(
                10'($urandom_range(0, 1) ? $urandom_range(1, 30) : $urandom_range(1, 1023)),
                5'($urandom_range(1, 16)),
                8'($urandom_range(0, 1) ? $urandom_range(1, 12) : $urandom_range(1, 255)),
                12'($urandom_range(1, 2048)), 4'($urandom), 1'($urandom));
        default: begin
          idle_on <= 1'b0;  // closing stretch runs flat out
          apply_geometry(10'd243, 5'd8, 8'd11, 12'd1024, 4'hF, 1'b0);
        end
      endcase

      if (ph == 0) begin
        // Drive the head far out so the image offset wraps past 32 bits.
        push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_CTRL, op_bits(hdcr_pkg::OP_RDATA));
        push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_DATA, 8'hFF);
        push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_CTRL,
                    CTRL_RUN | op_bits(hdcr_pkg::OP_RDATA));
        push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_CTRL, op_bits(hdcr_pkg::OP_RHDR));
        for (k = 0; k < 300; k++)
          push_access(hdcr_pkg::REQ_READ, hdcr_pkg::PORT_DATA, 8'($urandom));
        push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_CTRL,
                    CTRL_RUN | op_bits(hdcr_pkg::OP_RHDR));
        push_access(hdcr_pkg::REQ_WRITE, hdcr_pkg::PORT_CTRL,
                    CTRL_RUN | op_bits(hdcr_pkg::OP_WHDR));
        push_access(hdcr_pkg::REQ_READ,  hdcr_pkg::PORT_CTRL, 8'h00);
        add_random_traffic(110);
      end else begin
        add_random_traffic(200);
      end

      if (ph == 3) begin
        // receiver backs off while the sender keeps offering
        while (access_q.size() > 150) @(negedge clk_i);
        rx_hold_req <= rx_hold_req + 1;
        // then the sender waits for every outstanding result
        while (access_q.size() > 60) @(negedge clk_i);
        sender_hold <= 1'b1;
        @(negedge clk_i);
        while (offering || expected_resp_q.size() != 0) @(negedge clk_i);
        sender_hold <= 1'b0;
      end
      wait_drained();
    end

    if (n_fail == 0 && expected_resp_q.size() == 0) begin
      $display("hard_disk_controller_registers verification clean");
    end else begin
      $display("hard_disk_controller_registers verification failed");
    end
    $finish;
  end

endmodule
